>>> hw/rtl/cfpll_pkg.sv
// Shared types, constants and the CORDIC angle table for the carrier FPLL mixer.
package cfpll_pkg;

    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ZW               = 34;
    localparam int ANG_IDX_W        = 5;

    localparam logic [15:0] RST_LOOP_ALPHA = 16'd655;
    localparam logic [31:0] RST_LOOP_BETA  = 32'd107374;
    localparam logic [15:0] RST_AFC_COEFF  = 16'd656;
    localparam logic [31:0] RST_START_FREQ = 32'd0;
    localparam logic [31:0] RST_MAG_MIN_SQ = 32'd16;
    localparam logic [14:0] RST_ERROR_GATE = 15'd16383;
    localparam logic        RST_CLIP_MODE  = 1'b0;

    typedef enum logic [2:0] {
        REG_LOOP_ALPHA = 3'd0,
        REG_LOOP_BETA  = 3'd1,
        REG_AFC_COEFF  = 3'd2,
        REG_START_FREQ = 3'd3,
        REG_MAG_MIN_SQ = 3'd4,
        REG_ERROR_GATE = 3'd5,
        REG_CLIP_MODE  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic start;
        logic vec_mode;
    } cordic_ctrl_t;

    function automatic logic [31:0] ang_tab(input logic [ANG_IDX_W-1:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

>>> hw/rtl/cfpll_cordic.sv
// Iterative CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
module cfpll_cordic #(
    parameter int CW    = 36,
    parameter int STEPS = cfpll_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cfpll_pkg::cordic_ctrl_t       ctrl,
    input  logic signed [CW-1:0]          x_init,
    input  logic signed [CW-1:0]          y_init,
    input  logic signed [cfpll_pkg::ZW-1:0] z_init,
    output logic signed [CW-1:0]          x,
    output logic signed [CW-1:0]          y,
    output logic signed [cfpll_pkg::ZW-1:0] z,
    output logic                          done
);

    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic signed [CW-1:0]            x_reg, y_reg, x_next, y_next, dx, dy;
    logic signed [cfpll_pkg::ZW-1:0] z_reg, z_next, za;
    logic [IW-1:0]                   idx_reg;
    logic                            busy_reg, done_reg, vec_reg, pos;

    always_comb begin
        dx = y_reg >>> idx_reg;
        dy = x_reg >>> idx_reg;
        za = signed'(cfpll_pkg::ZW'(cfpll_pkg::ang_tab(cfpll_pkg::ANG_IDX_W'(idx_reg))));
        pos = vec_reg ? !(y_reg > 0) : (z_reg >= 0);
        if (pos) begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - za;
        end else begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + za;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (busy_reg) begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == IW'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            x_reg   <= x_init;
            y_reg   <= y_init;
            z_reg   <= z_init;
            vec_reg <= ctrl.vec_mode;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign done = done_reg;

endmodule

>>> hw/rtl/cfpll_mul.sv
// Shared signed multiplier with a registered product.
module cfpll_mul #(
    parameter int WA = 19,
    parameter int WB = 35
) (
    input  logic                    aclk,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);

    logic signed [WA+WB-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= (WA+WB)'(a) * (WA+WB)'(b);
    end

    assign p = p_reg;

endmodule

>>> hw/rtl/carrier_fpll_mixer.sv
// Carrier FPLL mixer top level: sequencer, loop state and configuration registers.
//
// Input channel s_*: one complex sample (s_in_i, s_in_q) per transaction.
// Output channel m_*: one result per sample: m_mixed_real, the real part of the
// sample times (sin + j cos) of the NCO, m_phase_error, the loop error applied
// after gating, and m_frozen, set when the sample was judged degenerate.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at once;
// write only while no sample is in flight.
// One CORDIC unit runs twice per sample (sin/cos, then the error angle), and one
// multiplier serves the mix, filter, magnitude and loop gain products.
// s_ready is high only between samples, so no new sample is accepted while one is
// in flight; the next sample can be accepted in the same cycle that m_valid rises.
// The result sits in an output register; a finished sample waits there while the
// receiver stalls, and the next sample is accepted meanwhile. If that sample
// finishes while the register is still held, the sequencer holds until it frees.
// Reset (aresetn low, synchronous) restores register defaults, clears the NCO
// phase, filter state and m_valid, and loads the NCO frequency with the start_freq default.
module carrier_fpll_mixer #(
    parameter int SAMPLE_BITS  = cfpll_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = cfpll_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_in_i,
    input  logic signed [SAMPLE_BITS-1:0] s_in_q,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS:0]   m_mixed_real,
    output logic signed [15:0]            m_phase_error,
    output logic                          m_frozen,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_wdata
);

    localparam int SB   = SAMPLE_BITS;
    localparam int MW   = SB + 1;
    localparam int AW   = SB + 18;
    localparam int DW   = SB + 19;
    localparam int RW   = SB + 3;
    localparam int CW   = (AW + 2 > 33) ? AW + 2 : 33;
    localparam int WA   = (RW > 17) ? RW : 17;
    localparam int WB   = (DW > 33) ? DW : 33;
    localparam int WP   = WA + WB;
    localparam int MGW  = 2 * RW + 1;
    localparam int CMPW = (MGW > 32) ? MGW : 32;
    localparam int ZW   = cfpll_pkg::ZW;

    typedef enum logic [18:0] {
        S_IDLE  = 19'b0000000000000000001,
        S_ROT   = 19'b0000000000000000010,
        S_RWAIT = 19'b0000000000000000100,
        S_MIX0  = 19'b0000000000000001000,
        S_MIX1  = 19'b0000000000000010000,
        S_MIX2  = 19'b0000000000000100000,
        S_MIX3  = 19'b0000000000001000000,
        S_MIX4  = 19'b0000000000010000000,
        S_AFC0  = 19'b0000000000100000000,
        S_AFC1  = 19'b0000000001000000000,
        S_AFC2  = 19'b0000000010000000000,
        S_VEC   = 19'b0000000100000000000,
        S_MAG   = 19'b0000001000000000000,
        S_MAG2  = 19'b0000010000000000000,
        S_VWAIT = 19'b0000100000000000000,
        S_LOOP0 = 19'b0001000000000000000,
        S_LOOP1 = 19'b0010000000000000000,
        S_LOOP2 = 19'b0100000000000000000,
        S_OUT   = 19'b1000000000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] alpha_reg, coeff_reg;
    logic [31:0] beta_reg, mag_min_reg;
    logic [14:0] gate_reg;
    logic        clip_reg;

    logic [31:0]          phase_reg;
    logic [47:0]          freq_reg;
    logic signed [AW-1:0] afc_r_reg, afc_i_reg;

    logic signed [SB-1:0] xi_reg, xq_reg;
    logic signed [15:0]   s_reg, c_reg, err_reg;
    logic signed [WP-1:0] acc_reg;
    logic signed [MW-1:0] mr_reg, mi_reg;
    logic [MGW-1:0]       mag_reg;
    logic                 frz_reg;

    logic                 m_valid_reg, m_frozen_reg;
    logic signed [MW-1:0] m_mixed_reg;
    logic signed [15:0]   m_err_reg;

    cfpll_pkg::cordic_ctrl_t cctrl;
    logic signed [CW-1:0]    cx_init, cy_init, cx, cy, xv, yv;
    logic signed [ZW-1:0]    cz_init, cz, zr, zv;
    logic                    cdone, flip, neg;
    logic [31:0]             q;

    logic signed [WA-1:0] mul_a;
    logic signed [WB-1:0] mul_b;
    logic signed [WP-1:0] mul_p;

    logic signed [DW-1:0] dr, di;
    logic signed [AW:0]   rr_t, ri_t;
    logic signed [RW-1:0] rr, ri;
    logic signed [15:0]   err_raw, err_gated;
    logic signed [16:0]   e17, eabs;
    logic                 degen;

    function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        t = ((CW+1)'(v) + (CW+1)'(16384)) >>> 15;
        if (t > (CW+1)'(32767)) begin
            return 16'sd32767;
        end else if (t < -(CW+1)'(32767)) begin
            return -16'sd32767;
        end else begin
            return 16'(t);
        end
    endfunction

    cfpll_cordic #(
        .CW    (CW),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cctrl),
        .x_init  (cx_init),
        .y_init  (cy_init),
        .z_init  (cz_init),
        .x       (cx),
        .y       (cy),
        .z       (cz),
        .done    (cdone)
    );

    cfpll_mul #(
        .WA (WA),
        .WB (WB)
    ) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    always_comb begin
        flip = phase_reg[31] ^ phase_reg[30];
        q    = {phase_reg[31] ^ flip, phase_reg[30:0]};
        neg  = afc_r_reg < 0;
        xv   = neg ? -CW'(afc_r_reg) : CW'(afc_r_reg);
        yv   = neg ? -CW'(afc_i_reg) : CW'(afc_i_reg);
        if (!neg) begin
            zv = '0;
        end else if (afc_i_reg >= 0) begin
            zv = ZW'(64'sd2147483648);
        end else begin
            zv = -ZW'(64'sd2147483648);
        end
        cctrl.start    = (state_reg == S_ROT) || (state_reg == S_VEC);
        cctrl.vec_mode = (state_reg == S_VEC);
        if (state_reg == S_VEC) begin
            cx_init = xv;
            cy_init = yv;
            cz_init = zv;
        end else begin
            cx_init = CW'(64'sd652032874);
            cy_init = '0;
            cz_init = ZW'(signed'(q));
        end
    end

    always_comb begin
        dr   = (DW'(mr_reg) <<< 16) - DW'(afc_r_reg);
        di   = (DW'(mi_reg) <<< 16) - DW'(afc_i_reg);
        rr_t = ((AW+1)'(afc_r_reg) + (AW+1)'(32768)) >>> 16;
        ri_t = ((AW+1)'(afc_i_reg) + (AW+1)'(32768)) >>> 16;
        rr   = RW'(rr_t);
        ri   = RW'(ri_t);
    end

    always_comb begin
        zr      = cz + ZW'(32768);
        err_raw = signed'(zr[31:16]);
        e17     = 17'(err_raw);
        eabs    = (e17 < 0) ? -e17 : e17;
        degen   = (CMPW'(mag_reg) < CMPW'(mag_min_reg)) ||
                  ($unsigned(eabs) >= {2'b00, gate_reg});
        err_gated = err_raw;
        if (degen) begin
            if (!clip_reg) begin
                err_gated = '0;
            end else if (err_raw > 16'sd16384) begin
                err_gated = 16'sd16384;
            end else if (err_raw < -16'sd16384) begin
                err_gated = -16'sd16384;
            end
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MIX0: begin
                mul_a = WA'(s_reg);
                mul_b = WB'(xi_reg);
            end
            S_MIX1: begin
                mul_a = WA'(c_reg);
                mul_b = WB'(xq_reg);
            end
            S_MIX2: begin
                mul_a = WA'(c_reg);
                mul_b = WB'(xi_reg);
            end
            S_MIX3: begin
                mul_a = WA'(s_reg);
                mul_b = WB'(xq_reg);
            end
            S_AFC0: begin
                mul_a = WA'(signed'({1'b0, coeff_reg}));
                mul_b = WB'(dr);
            end
            S_AFC1: begin
                mul_a = WA'(signed'({1'b0, coeff_reg}));
                mul_b = WB'(di);
            end
            S_VEC: begin
                mul_a = WA'(rr);
                mul_b = WB'(rr);
            end
            S_MAG: begin
                mul_a = WA'(ri);
                mul_b = WB'(ri);
            end
            S_LOOP0: begin
                mul_a = WA'(err_reg);
                mul_b = WB'(signed'({1'b0, alpha_reg}));
            end
            S_LOOP1: begin
                mul_a = WA'(err_reg);
                mul_b = WB'(signed'({1'b0, beta_reg}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_ROT;
            S_ROT:   state_next = S_RWAIT;
            S_RWAIT: if (cdone) state_next = S_MIX0;
            S_MIX0:  state_next = S_MIX1;
            S_MIX1:  state_next = S_MIX2;
            S_MIX2:  state_next = S_MIX3;
            S_MIX3:  state_next = S_MIX4;
            S_MIX4:  state_next = S_AFC0;
            S_AFC0:  state_next = S_AFC1;
            S_AFC1:  state_next = S_AFC2;
            S_AFC2:  state_next = S_VEC;
            S_VEC:   state_next = S_MAG;
            S_MAG:   state_next = S_MAG2;
            S_MAG2:  state_next = S_VWAIT;
            S_VWAIT: if (cdone) state_next = S_LOOP0;
            S_LOOP0: state_next = S_LOOP1;
            S_LOOP1: state_next = S_LOOP2;
            S_LOOP2: state_next = S_OUT;
            S_OUT:   if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            alpha_reg   <= cfpll_pkg::RST_LOOP_ALPHA;
            beta_reg    <= cfpll_pkg::RST_LOOP_BETA;
            coeff_reg   <= cfpll_pkg::RST_AFC_COEFF;
            mag_min_reg <= cfpll_pkg::RST_MAG_MIN_SQ;
            gate_reg    <= cfpll_pkg::RST_ERROR_GATE;
            clip_reg    <= cfpll_pkg::RST_CLIP_MODE;
            phase_reg   <= '0;
            freq_reg    <= {cfpll_pkg::RST_START_FREQ, 16'h0000};
            afc_r_reg   <= '0;
            afc_i_reg   <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE: if (s_valid) begin
                    phase_reg <= phase_reg + freq_reg[47:16];
                end
                S_AFC1:  afc_r_reg <= afc_r_reg + AW'(mul_p >>> 16);
                S_AFC2:  afc_i_reg <= afc_i_reg + AW'(mul_p >>> 16);
                S_LOOP1: phase_reg <= phase_reg + mul_p[31:0];
                S_LOOP2: freq_reg  <= freq_reg + mul_p[47:0];
                default: begin
                end
            endcase
            if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    cfpll_pkg::REG_LOOP_ALPHA: alpha_reg   <= cfg_wdata[15:0];
                    cfpll_pkg::REG_LOOP_BETA:  beta_reg    <= cfg_wdata;
                    cfpll_pkg::REG_AFC_COEFF:  coeff_reg   <= cfg_wdata[15:0];
                    cfpll_pkg::REG_START_FREQ: freq_reg    <= {cfg_wdata, 16'h0000};
                    cfpll_pkg::REG_MAG_MIN_SQ: mag_min_reg <= cfg_wdata;
                    cfpll_pkg::REG_ERROR_GATE: gate_reg    <= cfg_wdata[14:0];
                    cfpll_pkg::REG_CLIP_MODE:  clip_reg    <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: if (s_valid) begin
                xi_reg <= s_in_i;
                xq_reg <= s_in_q;
            end
            S_RWAIT: if (cdone) begin
                c_reg <= to_q15(flip ? -cx : cx);
                s_reg <= to_q15(flip ? -cy : cy);
            end
            S_MIX1:  acc_reg <= mul_p;
            S_MIX2:  mr_reg  <= MW'((acc_reg - mul_p) >>> 15);
            S_MIX3:  acc_reg <= mul_p;
            S_MIX4:  mi_reg  <= MW'((acc_reg + mul_p) >>> 15);
            S_MAG:   mag_reg <= mul_p[MGW-1:0];
            S_MAG2:  mag_reg <= mag_reg + mul_p[MGW-1:0];
            S_VWAIT: if (cdone) begin
                err_reg <= err_gated;
                frz_reg <= degen;
            end
            S_OUT: if (!m_valid_reg || m_ready) begin
                m_mixed_reg  <= mr_reg;
                m_err_reg    <= err_reg;
                m_frozen_reg <= frz_reg;
            end
            default: begin
            end
        endcase
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_mixed_real  = m_mixed_reg;
    assign m_phase_error = m_err_reg;
    assign m_frozen      = m_frozen_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a transaction is in flight");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_OUT))
        else $error("result presented outside the output state");

    a_pi_is_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frozen |-> m_phase_error != -16'sd32768)
        else $error("error of pi passed the gate");
`endif

endmodule
